>>> sv/wstq_pkg.sv
package wstq_pkg;

   localparam int OP_W        = 2;
   localparam int SEL_W       = 3;
   localparam int TASK_ID_W   = 16;
   localparam int STATUS_W    = 2;
   localparam int MOVED_W     = 7;
   localparam int STEAL_W     = 32;
   localparam int ACTIVE_W    = 4;

   localparam logic [OP_W-1:0] OP_PUSH    = 2'd0;
   localparam logic [OP_W-1:0] OP_POP     = 2'd1;
   localparam logic [OP_W-1:0] OP_BALANCE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

   typedef struct packed {
      logic [OP_W-1:0]      op;
      logic [SEL_W-1:0]     queue_sel;
      logic [TASK_ID_W-1:0] task_id;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [TASK_ID_W-1:0] out_task;
      logic [MOVED_W-1:0]   moved;
      logic [STEAL_W-1:0]   steals_total;
   } rsp_type;

endpackage

>>> sv/wstq_ram.sv
module wstq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/work_stealing_task_queues_unit.sv
// Per-processor task FIFOs with push, pop and work-stealing balance. An item is
// taken when start is high and busy is low; its result appears on rsp_data for
// exactly one cycle with rsp_strobe, and the receiver cannot stall it. Every
// request first reads the pointer entry of its queue; a pop of a non-empty
// queue then reads the task memory before the result. In a balance, every
// visited queue costs one read of its pointer entry, and every stolen task
// costs one read and one write of the task memory, which has a single read and
// a single write port. busy stays high until the result has been issued. The
// csr port is always ready and should be written only while the block is idle.
module work_stealing_task_queues_unit
   import wstq_pkg::*;
#(
   parameter int NUM_QUEUES  = 8,
   parameter int QUEUE_DEPTH = 64,
   parameter int TASK_BITS   = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  req_type             req_data,
   output logic                rsp_strobe,
   output rsp_type             rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [ACTIVE_W-1:0] csr_wdata
);

   localparam int QW  = $clog2(NUM_QUEUES);
   localparam int SLW = $clog2(QUEUE_DEPTH);
   localparam int CW  = $clog2(QUEUE_DEPTH + 1);
   localparam int RW  = $clog2(NUM_QUEUES + 1);
   localparam int STORE_DEPTH = NUM_QUEUES * (2 ** SLW);
   localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

   typedef struct packed {
      logic [SLW-1:0]     head;
      logic [SLW-1:0]     tail;
      logic [CW-1:0]      count;
      logic [STEAL_W-1:0] steals;
   } meta_type;

   localparam int MW = $bits(meta_type);

   typedef enum logic [2:0] {
      ST_IDLE, ST_EXEC, ST_POP, ST_META, ST_MOVE, ST_PUT, ST_DONE
   } state_type;

   function automatic logic [QW-1:0] reduce_sel(input logic [SEL_W-1:0] sel);
      int v;
      v = int'(sel);
      for (int i = 0; i < 8; i++) begin
         if (v >= NUM_QUEUES) begin
            v = v - NUM_QUEUES;
         end
      end
      return QW'(v);
   endfunction

   function automatic logic [SLW-1:0] next_slot(input logic [SLW-1:0] p);
      return (32'(p) == QUEUE_DEPTH - 1) ? '0 : SLW'(p + 1'b1);
   endfunction

   function automatic logic [QW-1:0] next_in_ring(input logic [QW-1:0] x,
                                                 input logic [RW-1:0] r);
      return (32'(x) + 32'd1 >= 32'(r)) ? '0 : QW'(x + 1'b1);
   endfunction

   state_type            state_ff, state_in;
   logic [OP_W-1:0]      op_ff, op_in;
   logic [QW-1:0]        own_ff, own_in;
   logic [QW-1:0]        oth_ff, oth_in;
   logic [TASK_BITS-1:0] task_ff, task_in;
   meta_type             own_meta_ff, own_meta_in;
   meta_type             oth_meta_ff, oth_meta_in;
   logic [CW-1:0]        start_cnt_ff, start_cnt_in;
   logic [CW-1:0]        left_ff, left_in;
   logic [CW-1:0]        moved_ff, moved_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   rsp_type              rsp_ff, rsp_in;
   logic [ACTIVE_W-1:0]  active_ff;
   logic                 meta_vld_ff [NUM_QUEUES];
   logic                 meta_rd_vld_ff;

   logic                 meta_we, meta_re;
   logic [QW-1:0]        meta_wa, meta_ra;
   meta_type             meta_wd;
   logic [MW-1:0]        meta_q;
   meta_type             rd_meta;

   logic                 st_we, st_re;
   logic [QW+SLW-1:0]    st_wa, st_ra;
   logic [TASK_BITS-1:0] st_wd, st_q;

   logic [RW-1:0]        ring;
   logic                 own_active;
   logic [QW-1:0]        own_next, oth_next;
   logic [QW-1:0]        req_q;

   always_comb begin
      int r;
      r = int'(active_ff);
      if (r == 0) begin
         r = 1;
      end
      if (r > NUM_QUEUES) begin
         r = NUM_QUEUES;
      end
      ring = RW'(r);
   end

   assign req_q      = reduce_sel(req_data.queue_sel);
   assign own_active = 32'(own_ff) < 32'(ring);
   assign own_next   = next_in_ring(own_ff, ring);
   assign oth_next   = next_in_ring(oth_ff, ring);
   assign rd_meta    = meta_rd_vld_ff ? meta_type'(meta_q) : '0;

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;
   assign csr_ready  = 1'b1;

   wstq_ram #(.WIDTH(MW), .DEPTH(NUM_QUEUES)) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (meta_wa),
      .wr_data (meta_wd),
      .rd_en   (meta_re),
      .rd_addr (meta_ra),
      .rd_data (meta_q)
   );

   wstq_ram #(.WIDTH(TASK_BITS), .DEPTH(STORE_DEPTH)) u_store_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_wa),
      .wr_data (st_wd),
      .rd_en   (st_re),
      .rd_addr (st_ra),
      .rd_data (st_q)
   );

   always_comb begin
      meta_type m;
      m             = rd_meta;
      state_in      = state_ff;
      op_in         = op_ff;
      own_in        = own_ff;
      oth_in        = oth_ff;
      task_in       = task_ff;
      own_meta_in   = own_meta_ff;
      oth_meta_in   = oth_meta_ff;
      start_cnt_in  = start_cnt_ff;
      left_in       = left_ff;
      moved_in      = moved_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;

      meta_we = 1'b0;
      meta_wa = own_ff;
      meta_wd = own_meta_ff;
      meta_re = 1'b0;
      meta_ra = own_ff;
      st_we   = 1'b0;
      st_wa   = {own_ff, own_meta_ff.tail};
      st_wd   = task_ff;
      st_re   = 1'b0;
      st_ra   = {oth_ff, oth_meta_ff.head};

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               meta_re  = 1'b1;
               meta_ra  = req_q;
               op_in    = req_data.op;
               own_in   = req_q;
               task_in  = TASK_BITS'(req_data.task_id);
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            own_meta_in         = m;
            rsp_in.status       = STATUS_OK;
            rsp_in.out_task     = '0;
            rsp_in.moved        = '0;
            rsp_in.steals_total = m.steals;
            unique case (op_ff)
               OP_PUSH: begin
                  if (m.count == FULL_CNT) begin
                     rsp_in.status = STATUS_FULL;
                  end else begin
                     st_we         = 1'b1;
                     st_wa         = {own_ff, m.tail};
                     st_wd         = task_ff;
                     meta_we       = 1'b1;
                     meta_wd       = m;
                     meta_wd.tail  = next_slot(m.tail);
                     meta_wd.count = m.count + 1'b1;
                  end
                  rsp_strobe_in = 1'b1;
                  state_in      = ST_IDLE;
               end
               OP_POP: begin
                  if (m.count == '0) begin
                     rsp_in.status = STATUS_EMPTY;
                     rsp_strobe_in = 1'b1;
                     state_in      = ST_IDLE;
                  end else begin
                     st_re         = 1'b1;
                     st_ra         = {own_ff, m.head};
                     meta_we       = 1'b1;
                     meta_wd       = m;
                     meta_wd.head  = next_slot(m.head);
                     meta_wd.count = m.count - 1'b1;
                     state_in      = ST_POP;
                  end
               end
               OP_BALANCE: begin
                  start_cnt_in = m.count;
                  moved_in     = '0;
                  if (own_active && own_next != own_ff) begin
                     oth_in   = own_next;
                     meta_re  = 1'b1;
                     meta_ra  = own_next;
                     state_in = ST_META;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
               default: begin
                  rsp_strobe_in = 1'b1;
                  state_in      = ST_IDLE;
               end
            endcase
         end
         ST_POP: begin
            rsp_in.out_task = TASK_ID_W'(st_q);
            rsp_strobe_in   = 1'b1;
            state_in        = ST_IDLE;
         end
         ST_META: begin
            oth_meta_in = m;
            left_in     = (m.count > start_cnt_ff) ? CW'((m.count - start_cnt_ff) >> 1) : '0;
            state_in    = ST_MOVE;
         end
         ST_MOVE: begin
            if (left_ff == '0 || oth_meta_ff.count == '0) begin
               // this victim is done; write its pointers back, go on around the ring
               meta_we = 1'b1;
               meta_wa = oth_ff;
               meta_wd = oth_meta_ff;
               if (oth_next == own_ff) begin
                  state_in = ST_DONE;
               end else begin
                  meta_re  = 1'b1;
                  meta_ra  = oth_next;
                  oth_in   = oth_next;
                  state_in = ST_META;
               end
            end else if (own_meta_ff.count == FULL_CNT) begin
               meta_we  = 1'b1;
               meta_wa  = oth_ff;
               meta_wd  = oth_meta_ff;
               state_in = ST_DONE;
            end else begin
               st_re             = 1'b1;
               st_ra             = {oth_ff, oth_meta_ff.head};
               oth_meta_in.head  = next_slot(oth_meta_ff.head);
               oth_meta_in.count = oth_meta_ff.count - 1'b1;
               left_in           = left_ff - 1'b1;
               state_in          = ST_PUT;
            end
         end
         ST_PUT: begin
            st_we              = 1'b1;
            st_wa              = {own_ff, own_meta_ff.tail};
            st_wd              = st_q;
            own_meta_in.tail   = next_slot(own_meta_ff.tail);
            own_meta_in.count  = own_meta_ff.count + 1'b1;
            own_meta_in.steals = own_meta_ff.steals + 1'b1;
            moved_in           = moved_ff + 1'b1;
            state_in           = ST_MOVE;
         end
         ST_DONE: begin
            meta_we             = 1'b1;
            meta_wa             = own_ff;
            meta_wd             = own_meta_ff;
            rsp_in.status       = STATUS_OK;
            rsp_in.out_task     = '0;
            rsp_in.moved        = MOVED_W'(moved_ff);
            rsp_in.steals_total = own_meta_ff.steals;
            rsp_strobe_in       = 1'b1;
            state_in            = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      own_ff       <= own_in;
      oth_ff       <= oth_in;
      task_ff      <= task_in;
      own_meta_ff  <= own_meta_in;
      oth_meta_ff  <= oth_meta_in;
      start_cnt_ff <= start_cnt_in;
      left_ff      <= left_in;
      moved_ff     <= moved_in;
      rsp_ff       <= rsp_in;
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_strobe_ff  <= 1'b0;
         active_ff      <= ACTIVE_RESET;
         meta_rd_vld_ff <= 1'b0;
         for (int i = 0; i < NUM_QUEUES; i++) begin
            meta_vld_ff[i] <= 1'b0;
         end
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_valid && csr_ready) begin
            active_ff <= csr_wdata;
         end
         // an entry never written reads as zero pointers and counts
         if (meta_re) begin
            meta_rd_vld_ff <= meta_vld_ff[meta_ra];
         end
         if (meta_we) begin
            meta_vld_ff[meta_wa] <= 1'b1;
         end
      end
   end

endmodule
